@@ rtl/sana_pkg.sv @@
// Shared constants, codes and helpers for the stochastic adaptive neuron array.
// No dependencies; imported by the array core.
`timescale 1ns / 1ps

package sana_pkg;

  // Array size default
  localparam int unsigned NeuronsDef = 16;

  // Stream payload widths
  localparam int unsigned InDataW  = 40;  // 6 + 16 + 16, padded to bytes
  localparam int unsigned OutDataW = 72;  // 7 + 1 + 16 + 16 + 32

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] RateRst  = 16'd655;
  localparam logic [15:0] ScaleRst = 16'd66;
  localparam logic [15:0] SeedRst  = 16'd44257;

  // Galois LFSR feedback taps
  localparam logic [15:0] LfsrTaps = 16'hB400;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RATE  = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_SEED  = 2'd2
  } cfg_e;

  // Advance the LFSR by one bit
  function automatic logic [15:0] lfsr_next(input logic [15:0] r);
    logic [15:0] s;
    s = {1'b0, r[15:1]};
    if (r[0]) begin
      s = s ^ LfsrTaps;
    end
    return s;
  endfunction

  // Clamp a 23-bit signed value to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [22:0] x);
    logic signed [15:0] y;
    if ((x[22:15] == 8'h00) || (x[22:15] == 8'hFF)) begin
      y = x[15:0];
    end else if (x[22]) begin
      y = 16'sh8000;
    end else begin
      y = 16'sh7FFF;
    end
    return y;
  endfunction

endpackage

@@ rtl/stochastic_adaptive_neuron_array_core.sv @@
// Stochastic adaptive neuron array: state memories and the per-neuron update pipeline.
// Depends on sana_pkg for codes, widths, LFSR step and saturation.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+---------------------------------------
//  s_axis   | in        | tvalid / tready      | tuser: command; tdata: index, coef, current
//  m_axis   | out       | tvalid / tready      | tdata: id, spike, v, w, step; tlast
//  cfg      | in        | cfg_we_i (no stall)  | cfg_idx_i, cfg_data_i
//
//  A tick request streams NEURONS results, one per cycle while the result stream is not
//  stalled, through a six-stage pipeline (memory read, a*w, drive*rate, new potential,
//  adaptation and spike products, result register). A stalled result stops the whole
//  pipeline. Reset clears the per-entry valid bits, so memory entries read as zero until
//  written; no clearing pass is needed. Requests are taken only when no tick is in flight.

module stochastic_adaptive_neuron_array_core
  import sana_pkg::*;
#(
  parameter int unsigned NEURONS = NeuronsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // neuron_index[5:0], coefficient[21:6],
                                                 // current[37:22], zero pad[39:38]
  input  logic                s_axis_tuser_i,   // command[0]
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // neuron_id[6:0], spike[7],
                                                 // potential[23:8], adaptation[39:24],
                                                 // step[71:40]
  output logic                m_axis_tlast_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NEURONS - 1);

  // Request fields
  logic [5:0]         in_idx;
  logic signed [15:0] in_coef;
  logic signed [15:0] in_cur;
  logic               s_fire;
  logic               is_tick;

  assign in_idx  = s_axis_tdata_i[5:0];
  assign in_coef = s_axis_tdata_i[21:6];
  assign in_cur  = s_axis_tdata_i[37:22];
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick = (s_axis_tuser_i == CMD_TICK);

  // Configuration and global state
  logic [15:0] rate_q, scale_q, lfsr_q, lfsr_n;
  logic [31:0] step_q;
  logic signed [15:0] cur_q;

  // Issue control
  logic            issuing_q;
  logic [IdxW-1:0] cnt_q;

  // Pipeline valids and indexes
  logic            p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q;
  logic [IdxW-1:0] p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q, p5_idx_q;
  logic            adv;

  // Memories and valid bits
  logic [31:0] st_mem [NEURONS];
  logic [15:0] cf_mem [NEURONS];
  logic [NEURONS-1:0] st_vld_q, cf_vld_q;
  logic [31:0] st_rd_q;
  logic [15:0] cf_rd_q;
  logic        st_ok_q, cf_ok_q;

  // Pipeline payload
  logic signed [15:0] p1_v, p1_w, p1_a;
  logic signed [31:0] p2_aw_q;
  logic signed [15:0] p2_v_q, p2_w_q;
  logic signed [20:0] p2_drive;
  logic signed [16:0] rate_s, scale_s;
  logic signed [37:0] p3_dp_q;
  logic signed [15:0] p3_v_q, p3_w_q;
  logic signed [22:0] p3_sum;
  logic signed [15:0] p4_vn_q, p4_w_q;
  logic signed [16:0] p4_diff;
  logic signed [33:0] p5_dw_q;
  logic signed [32:0] p5_lhs_q;
  logic signed [15:0] p5_vn_q, p5_w_q;
  logic signed [22:0] p5_wsum;
  logic signed [15:0] p5_wn;
  logic               p5_spike;

  // Output register
  logic                m_vld_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_last_q;

  // Advance the pipeline unless a result waits
  assign adv = !m_vld_q || m_axis_tready_i;

  // Take a request only with nothing in flight
  assign s_axis_tready_o = !issuing_q && !p1_vld_q && !p2_vld_q && !p3_vld_q
                           && !p4_vld_q && !p5_vld_q;

  assign rate_s  = $signed({1'b0, rate_q});
  assign scale_s = $signed({1'b0, scale_q});

  // Configuration registers, LFSR and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateRst;
      scale_q <= ScaleRst;
      lfsr_q  <= SeedRst;
      step_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RATE:  rate_q  <= cfg_data_i;
          CFG_SCALE: scale_q <= cfg_data_i;
          CFG_SEED:  lfsr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (adv && p5_vld_q) begin
        lfsr_q <= lfsr_n;
        if (p5_idx_q == LastIdx) begin
          step_q <= step_q + 32'd1;
        end
      end
    end
  end

  // Issue counter: walk the neurons once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      cnt_q     <= '0;
    end else if (s_fire && is_tick) begin
      issuing_q <= 1'b1;
      cnt_q     <= '0;
    end else if (adv && issuing_q) begin
      cnt_q <= cnt_q + IdxW'(1);
      if (cnt_q == LastIdx) begin
        issuing_q <= 1'b0;
      end
    end
  end

  // Latch the shared current of a tick
  always_ff @(posedge clk_i) begin
    if (s_fire && is_tick) begin
      cur_q <= in_cur;
    end
  end

  // Coefficient memory: load writes, tick reads
  always_ff @(posedge clk_i) begin
    if (s_fire && !is_tick && ({1'b0, in_idx} < 7'(NEURONS))) begin
      cf_mem[in_idx[IdxW-1:0]] <= in_coef;
    end
    if (adv && issuing_q) begin
      cf_rd_q <= cf_mem[cnt_q];
    end
  end

  // State memory: read at issue, write back from the last stage
  always_ff @(posedge clk_i) begin
    if (adv && p5_vld_q) begin
      st_mem[p5_idx_q] <= {p5_vn_q, p5_wn};
    end
    if (adv && issuing_q) begin
      st_rd_q <= st_mem[cnt_q];
    end
  end

  // Valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      cf_vld_q <= '0;
      st_ok_q  <= 1'b0;
      cf_ok_q  <= 1'b0;
    end else begin
      if (s_fire && !is_tick && ({1'b0, in_idx} < 7'(NEURONS))) begin
        cf_vld_q[in_idx[IdxW-1:0]] <= 1'b1;
      end
      if (adv && p5_vld_q) begin
        st_vld_q[p5_idx_q] <= 1'b1;
      end
      if (adv && issuing_q) begin
        st_ok_q <= st_vld_q[cnt_q];
        cf_ok_q <= cf_vld_q[cnt_q];
      end
    end
  end

  // Pipeline valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= issuing_q;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
      m_vld_q  <= p5_vld_q;
    end
  end

  // Stage 1: mask memory data, form a*w
  assign p1_v = st_ok_q ? $signed(st_rd_q[31:16]) : 16'sd0;
  assign p1_w = st_ok_q ? $signed(st_rd_q[15:0]) : 16'sd0;
  assign p1_a = cf_ok_q ? $signed(cf_rd_q) : 16'sd0;

  // Stage 2: drive = current - v - floor(a*w / 4096)
  assign p2_drive = {{5{cur_q[15]}}, cur_q} - {{5{p2_v_q[15]}}, p2_v_q}
                    - {p2_aw_q[31], p2_aw_q[31:12]};

  // Stage 3: new potential
  assign p3_sum = {{7{p3_v_q[15]}}, p3_v_q} + {p3_dp_q[37], p3_dp_q[37:16]};

  // Stage 4: adaptation error
  assign p4_diff = {p4_vn_q[15], p4_vn_q} - {p4_w_q[15], p4_w_q};

  // Stage 5: new adaptation and spike test against the next draw
  assign p5_wsum  = {{7{p5_w_q[15]}}, p5_w_q} + {{5{p5_dw_q[33]}}, p5_dw_q[33:16]};
  assign p5_wn    = sat16(p5_wsum);
  assign lfsr_n   = lfsr_next(lfsr_q);
  assign p5_spike = p5_lhs_q > $signed({5'b0, lfsr_n, 12'b0});

  // Pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_idx_q <= cnt_q;
      p2_idx_q <= p1_idx_q;
      p2_aw_q  <= p1_a * p1_w;
      p2_v_q   <= p1_v;
      p2_w_q   <= p1_w;
      p3_idx_q <= p2_idx_q;
      p3_dp_q  <= p2_drive * rate_s;
      p3_v_q   <= p2_v_q;
      p3_w_q   <= p2_w_q;
      p4_idx_q <= p3_idx_q;
      p4_vn_q  <= sat16(p3_sum);
      p4_w_q   <= p3_w_q;
      p5_idx_q <= p4_idx_q;
      p5_dw_q  <= p4_diff * rate_s;
      p5_lhs_q <= p4_vn_q * scale_s;
      p5_vn_q  <= p4_vn_q;
      p5_w_q   <= p4_w_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv && p5_vld_q) begin
      m_data_q <= {step_q, p5_wn, p5_vn_q, p5_spike, 7'(p5_idx_q) + 7'd1};
      m_last_q <= (p5_idx_q == LastIdx);
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for the stochastic adaptive neuron array core.
// Streams load and tick requests, predicts every neuron update and checks the result stream.
// Depends on sana_pkg and stochastic_adaptive_neuron_array_core.
`timescale 1ns / 1ps

module testbench;
  import sana_pkg::*;

  localparam int unsigned NEURONS = NeuronsDef;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 10;

  typedef struct packed {
    cmd_e               cmd;
    logic [5:0]         index;
    logic signed [15:0] coef;
    logic signed [15:0] current;
    logic               drain;
  } request_t;

  typedef struct packed {
    logic [6:0]  id;
    logic        spike;
    logic [15:0] potential;
    logic [15:0] adaptation;
    logic [31:0] step;
    logic        last;
  } neuron_update_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                req_valid = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  req_data = '0;
  logic                req_user = 1'b0;
  logic                m_axis_tvalid_o;
  logic                res_ready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Pending requests and predicted neuron updates
  request_t       request_q[$];
  neuron_update_t neuron_updates_q[$];

  // Mirror of the array state and registers
  logic signed [15:0] pot_m[NEURONS];
  logic signed [15:0] adp_m[NEURONS];
  logic signed [15:0] coef_m[NEURONS];
  logic [15:0]        lfsr_m;
  logic [31:0]        step_m;
  logic [15:0]        rate_m;
  logic [15:0]        scale_m;

  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  bit          holding = 1'b0;
  request_t    cur_req = '0;

  stochastic_adaptive_neuron_array_core #(
    .NEURONS(NEURONS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (req_data),
    .s_axis_tuser_i (req_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Append one request to the pending queue
  function automatic void add_request(input request_t req);
    request_q.insert(request_q.size(), req);
  endfunction

  // Clamp to the signed Q4.12 range
  function automatic logic signed [15:0] clamp_q412(input longint x);
    if (x > 32767) begin
      return 16'sh7FFF;
    end else if (x < -32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  // Advance every neuron by one Euler step and queue the predicted updates
  function automatic void step_neurons(input logic signed [15:0] cur);
    longint v, w, a, aw, drive, vn, wn, r, s, lhs, rhs, rnd;
    neuron_update_t u;
    r = rate_m;
    s = scale_m;
    for (int i = 0; i < NEURONS; i++) begin
      v = pot_m[i];
      w = adp_m[i];
      a = coef_m[i];
      aw = (a * w) >>> 12;
      drive = -aw - v + longint'(cur);
      vn = clamp_q412(v + ((drive * r) >>> 16));
      wn = clamp_q412(w + (((vn - w) * r) >>> 16));
      pot_m[i] = vn[15:0];
      adp_m[i] = wn[15:0];
      lfsr_m = {1'b0, lfsr_m[15:1]} ^ (lfsr_m[0] ? LfsrTaps : 16'h0000);
      rnd = lfsr_m;
      lhs = vn * s;
      rhs = rnd << 12;
      u.id = 7'(i + 1);
      u.spike = (lhs > rhs);
      u.potential = vn[15:0];
      u.adaptation = wn[15:0];
      u.step = step_m;
      u.last = (i == NEURONS - 1);
      neuron_updates_q.insert(neuron_updates_q.size(), u);
    end
    step_m = step_m + 32'd1;
  endfunction

  // Apply one accepted request to the mirror
  function automatic void predict_request(input request_t req);
    if (req.cmd == CMD_LOAD) begin
      if (req.index < NEURONS) begin
        coef_m[req.index] = req.coef;
      end
    end else begin
      step_neurons(req.current);
    end
  endfunction

  function automatic logic signed [15:0] random_q412();
    case ($urandom_range(7, 0))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(8191, 0)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t req;
    req.cmd = ($urandom_range(99, 0) < 55) ? CMD_TICK : CMD_LOAD;
    req.index = ($urandom_range(4, 0) != 0) ? 6'($urandom_range(NEURONS - 1, 0))
                                            : 6'($urandom_range(63, NEURONS));
    req.coef = random_q412();
    req.current = random_q412();
    req.drain = ($urandom_range(39, 0) == 0);
    return req;
  endfunction

  function automatic request_t make_request(input cmd_e cmd, input logic [5:0] index,
                                            input logic signed [15:0] coef,
                                            input logic signed [15:0] current);
    request_t req;
    req.cmd = cmd;
    req.index = index;
    req.coef = coef;
    req.current = current;
    req.drain = 1'b0;
    return req;
  endfunction

  // Write one register and mirror it; seed also restarts the random word
  task automatic write_reg(input cfg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RATE: rate_m = val;
      CFG_SCALE: scale_m = val;
      CFG_SEED: lfsr_m = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is taken and every update has come, then let the core settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || req_valid || neuron_updates_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] rate, input logic [15:0] scale,
                           input logic [15:0] seed, input int unsigned count,
                           input int unsigned tx_max, input int unsigned rx_max);
    request_t req;
    wait_idle();
    write_reg(CFG_RATE, rate);
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_SEED, seed);
    @(negedge clk_i);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    for (int n = 0; n < count; n++) begin
      req = random_request();
      if (n == count / 2) begin
        req.drain = 1'b1;
      end
      add_request(req);
    end
  endtask

  // Stimulus: reset, directed requests, then randomized phases
  initial begin
    rate_m = RateRst;
    scale_m = ScaleRst;
    lfsr_m = SeedRst;
    step_m = '0;
    for (int i = 0; i < NEURONS; i++) begin
      pot_m[i] = '0;
      adp_m[i] = '0;
      coef_m[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    tx_gap_max = 3;
    rx_gap_max = 0;

    // Directed: reset settings, extreme coefficients, out-of-range loads, extreme currents
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'sd0));
    add_request(make_request(CMD_LOAD, 6'd0, 16'sh7FFF, 16'sh7FFF));
    add_request(make_request(CMD_LOAD, 6'(NEURONS - 1), 16'sh8000, 16'sh8000));
    add_request(make_request(CMD_LOAD, 6'(NEURONS), 16'sd12345, 16'sd0));
    add_request(make_request(CMD_LOAD, 6'd63, 16'shFFFF, 16'shFFFF));
    add_request(make_request(CMD_LOAD, 6'd7, 16'sh1000, 16'sd0));
    add_request(make_request(CMD_TICK, 6'd63, 16'shFFFF, 16'sh7FFF));
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'sh7FFF));
    add_request(make_request(CMD_TICK, 6'd21, 16'sh5555, 16'sh7FFF));
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'sh8000));
    add_request(make_request(CMD_TICK, 6'd42, 16'shAAAA, 16'sh8000));
    add_request(make_request(CMD_LOAD, 6'd0, 16'sh8000, 16'sd0));
    add_request(make_request(CMD_LOAD, 6'(NEURONS - 1), 16'sh7FFF, 16'sd0));
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'sh7FFF));
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'shFFFF));
    add_request(make_request(CMD_TICK, 6'd0, 16'sd0, 16'sd0));
    add_request(make_request(CMD_LOAD, 6'd3, 16'shC000, 16'sh4000));

    // Random phases: extremes, zero seed, and random settings
    run_phase(16'hFFFF, 16'hFFFF, 16'h0001, 45, 11, 11);
    run_phase(16'h0000, 16'h0000, 16'hFFFF, 35, 0, 0);
    run_phase(16'($urandom), 16'($urandom), 16'h0000, 45, 11, 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)), 45, 0, 11);
    run_phase(16'h1000, 16'd20000, 16'($urandom_range(65535, 1)), 45, 11, 11);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && neuron_updates_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Request driver: random gap per request, optional drain before a request
  always @(posedge clk_i) begin : drive_proc
    if (rst_ni) begin
      if (holding && s_axis_tready_o) begin
        predict_request(cur_req);
        holding = 1'b0;
        tx_wait = $urandom_range(tx_gap_max, 0);
      end else if (!holding && tx_wait > 0) begin
        tx_wait--;
      end
      if (!holding && tx_wait == 0 && request_q.size() != 0) begin
        if (!request_q[0].drain || neuron_updates_q.size() == 0) begin
          cur_req = request_q.pop_front();
          holding = 1'b1;
        end
      end
      req_valid <= holding;
      req_data <= {2'b00, cur_req.current, cur_req.coef, cur_req.index};
      req_user <= cur_req.cmd;
    end
  end

  // Result monitor: compare each update with the oldest prediction, stall at random
  always @(posedge clk_i) begin : watch_proc
    neuron_update_t want;
    neuron_update_t got;
    if (rst_ni) begin
      quiet_cycles++;
      if (req_valid && s_axis_tready_o) begin
        quiet_cycles = 0;
      end
      if (m_axis_tvalid_o && res_ready) begin
        quiet_cycles = 0;
        got.id = m_axis_tdata_o[6:0];
        got.spike = m_axis_tdata_o[7];
        got.potential = m_axis_tdata_o[23:8];
        got.adaptation = m_axis_tdata_o[39:24];
        got.step = m_axis_tdata_o[71:40];
        got.last = m_axis_tlast_o;
        if (neuron_updates_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected update: id %0d spike %0b v %h w %h step %0d last %0b",
                     got.id, got.spike, got.potential, got.adaptation, got.step, got.last);
          end
        end else begin
          want = neuron_updates_q.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("update mismatch: expected id %0d spike %0b v %h w %h step %0d last %0b",
                       want.id, want.spike, want.potential, want.adaptation, want.step,
                       want.last);
              $display("                 actual   id %0d spike %0b v %h w %h step %0d last %0b",
                       got.id, got.spike, got.potential, got.adaptation, got.step, got.last);
            end
          end
        end
        rx_wait = $urandom_range(rx_gap_max, 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      res_ready <= (rx_wait == 0);
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
